@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file.
// Clocked, reset-qualified properties that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/deqs_pkg.sv @@
// ----------------------------------------------------------------------------
// deqs_pkg
// Types and operation codes shared by the deque controller and datapath.
// ----------------------------------------------------------------------------
package deqs_pkg;

    // Operation codes carried in the request op field.
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_REM_FRONT = 3'd2;
    localparam logic [2:0] OP_REM_BACK  = 3'd3;
    localparam logic [2:0] OP_SEARCH    = 3'd4;

    // Request payload.
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } req_item_t;

    // Response payload.
    typedef struct packed {
        logic       found;
        logic       empty_after;
        logic       dropped;
        logic [4:0] occupancy;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan_read;
        logic check;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic last_read;
        logic hit;
    } status_t;

endpackage

@@ src/deqs_datapath.sv @@
// ----------------------------------------------------------------------------
// deqs_datapath
// Ring store, front index and entry count, search scan and response register.
// ----------------------------------------------------------------------------
module deqs_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  deqs_pkg::req_item_t req_item,
    input  deqs_pkg::cmd_t      cmd,
    output deqs_pkg::status_t   status,
    output deqs_pkg::rsp_item_t rsp_item
);
    import deqs_pkg::*;

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int SW  = CW + 1;
    localparam int IW1 = IW + 1;
    localparam int OW  = CW + 5;

    localparam logic [SW-1:0]  CAP_S   = SW'(CAPACITY);
    localparam logic [IW1-1:0] CAP_I   = IW1'(CAPACITY);
    localparam logic [IW-1:0]  LAST_I  = IW'(CAPACITY - 1);
    localparam logic [CW-1:0]  CAP_C   = CW'(CAPACITY);

    logic [31:0]    mem [CAPACITY];

    logic [IW-1:0]  front_reg, front_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  scan_off_reg;
    logic [IW-1:0]  scan_addr_reg;
    logic [31:0]    rd_data_reg;
    logic           rd_valid_reg;
    logic [31:0]    value_reg;
    logic           found_reg;
    logic           dropped_reg;
    rsp_item_t      rsp_reg;

    logic           full;
    logic           empty;
    logic           is_insert;
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [IW-1:0]  front_dec;
    logic [IW1-1:0] front_inc_w;
    logic [IW-1:0]  front_inc;
    logic [IW1-1:0] scan_inc_w;
    logic [IW-1:0]  scan_inc;
    logic [SW-1:0]  back_sum;
    logic [SW-1:0]  back_pos;
    logic [OW-1:0]  occ_wide;

    assign full  = (count_reg == CAP_C);
    assign empty = (count_reg == '0);

    // Ring neighbors of the front index and of the scan address.
    assign front_dec   = (front_reg == '0) ? LAST_I : front_reg - 1'b1;
    assign front_inc_w = {1'b0, front_reg} + 1'b1;
    assign front_inc   = (front_inc_w == CAP_I) ? '0 : front_inc_w[IW-1:0];
    assign scan_inc_w  = {1'b0, scan_addr_reg} + 1'b1;
    assign scan_inc    = (scan_inc_w == CAP_I) ? '0 : scan_inc_w[IW-1:0];

    // Slot just past the back entry.
    assign back_sum = SW'(front_reg) + SW'(count_reg);
    assign back_pos = (back_sum >= CAP_S) ? back_sum - CAP_S : back_sum;

    assign is_insert = (req_item.op == OP_INS_FRONT) || (req_item.op == OP_INS_BACK);
    assign wr_en     = cmd.start && is_insert && !full;
    assign wr_addr   = (req_item.op == OP_INS_FRONT) ? front_dec : back_pos[IW-1:0];

    // Status toward the controller.
    assign status.need_scan = (req_item.op == OP_SEARCH) && !empty;
    assign status.last_read = ((SW'(scan_off_reg) + 1'b1) == SW'(count_reg));
    assign status.hit       = rd_valid_reg && (rd_data_reg == value_reg);

    // Next front index and count for the operation being accepted.
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.start)
        begin
            unique case (req_item.op)
                OP_INS_FRONT:
                begin
                    if (!full)
                    begin
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_INS_BACK:
                begin
                    if (!full)
                        count_next = count_reg + 1'b1;
                end
                OP_REM_FRONT:
                begin
                    if (!empty)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_REM_BACK:
                begin
                    if (!empty)
                        count_next = count_reg - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state of the sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            rd_valid_reg <= cmd.scan_read;
        end
    end

    // Ring store with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= req_item.value;
        if (cmd.scan_read)
            rd_data_reg <= mem[scan_addr_reg];
    end

    // Scan position, search key and per-item flags.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            scan_off_reg  <= '0;
            scan_addr_reg <= front_reg;
            value_reg     <= req_item.value;
            found_reg     <= 1'b0;
            dropped_reg   <= is_insert && full;
        end
        else
        begin
            if (cmd.scan_read)
            begin
                scan_off_reg  <= scan_off_reg + 1'b1;
                scan_addr_reg <= scan_inc;
            end
            if (cmd.check && status.hit)
                found_reg <= 1'b1;
        end
    end

    // Response register; the occupancy is the count masked to five bits.
    assign occ_wide = {5'b0, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_reg.found       <= found_reg;
            rsp_reg.empty_after <= empty;
            rsp_reg.dropped     <= dropped_reg;
            rsp_reg.occupancy   <= occ_wide[4:0];
        end
    end

    assign rsp_item = rsp_reg;

endmodule

@@ src/deqs_controller.sv @@
// ----------------------------------------------------------------------------
// deqs_controller
// Sequences one operation at a time and owns both channel handshakes.
// ----------------------------------------------------------------------------
module deqs_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  deqs_pkg::status_t status,
    output deqs_pkg::cmd_t    cmd
);
    import deqs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // A request transfer is taken only between operations.
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.need_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                // Compare the previous read while issuing the next one.
                cmd.check = 1'b1;
                if (status.hit)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.scan_read = 1'b1;
                    if (status.last_read)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.check  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The response stays valid until its transfer completes.
    always_comb
    begin
        if (cmd.load_out)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

@@ src/double_ended_queue_with_search.sv @@
// Insert, removal and no-op results are loaded into the response register in FINISH, the
// state after the transfer, once the output is free. A search of a non-empty deque passes
// through SCAN and DRAIN to FINISH; a hit ends it early, from SCAN. A new request is taken
// only after the last is through; the scan reads one entry a cycle from the single read port.
// Reset clears the front index, the entry count and the control state; the store
// itself is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Deque of signed 32-bit values in a ring store with membership search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue_with_search #(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  deqs_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output deqs_pkg::rsp_item_t rsp_item
);
    import deqs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer for operations and handshakes.
    deqs_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Store, indexes and result register.
    deqs_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_item (req_item),
        .cmd      (cmd),
        .status   (status),
        .rsp_item (rsp_item)
    );

    // An accepted request keeps the block busy in the cycle after it.
    `ASSERT_NEXT(a_busy_after_start, clk, rst_n, cmd.start, req_stall)

    // A new result never overwrites one that is still waiting.
    `ASSERT_SAME(a_load_when_free, clk, rst_n, cmd.load_out, !rsp_valid || !rsp_stall)

    // A refused insert never reports a search hit.
    `ASSERT_SAME(a_drop_not_found, clk, rst_n, rsp_valid, !(rsp_item.found && rsp_item.dropped))

    // A loaded result is presented in the next cycle.
    `ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load_out, rsp_valid)

endmodule
